// File: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CIV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CIV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/civ_pkg.sv
`timescale 1ns / 1ps
package civ_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [1:0] OCTET_MAX_LEN = 2'd3;
  localparam logic [1:0] V4_DOTS       = 2'd3;
  localparam logic [9:0] OCTET_MAX     = 10'd255;
  localparam logic [2:0] HEX_MAX_LEN   = 3'd4;
  localparam logic [2:0] PART_LEN_SAT  = 3'd5;
  localparam logic [3:0] GROUPS_SAT    = 4'd15;
  localparam logic [4:0] V6_GROUPS     = 5'd8;
  localparam logic [1:0] RUN_SAT       = 2'd3;
  localparam logic [1:0] DCOLON_SAT    = 2'd2;
  localparam logic [2:0] PFX_MAX_LEN   = 3'd3;
  localparam logic [2:0] PFX_LEN_SAT   = 3'd4;
  localparam logic [9:0] V4_MAX_BITS   = 10'd32;
  localparam logic [9:0] V6_MAX_BITS   = 10'd128;

  localparam logic [1:0] MODE_V4    = 2'd0;
  localparam logic [1:0] MODE_V6    = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_V4   = 2'd1;
  localparam logic [1:0] FAM_V6   = 2'd2;

  typedef enum logic [1:0] {
    TRIM_LEAD,
    TRIM_IN,
    TRIM_TAIL
  } trim_t;

  typedef struct packed {
    logic [1:0] olen;
    logic [9:0] oval;
    logic       first_zero;
    logic [1:0] dots;
    logic       bad;
  } quad_t;

  typedef struct packed {
    logic       colon_seen;
    logic [1:0] run;
    logic [1:0] dcolon;
    logic [3:0] groups;
    logic       empty_part;
    logic [2:0] part_len;
    logic       part_hex;
    logic       part_dot;
  } v6_t;

  typedef struct packed {
    logic       slash_seen;
    logic [2:0] plen;
    logic [9:0] pval;
    logic       bad;
  } pfx_t;

  typedef struct packed {
    trim_t trim;
    quad_t v4;
    v6_t   v6;
    quad_t tail;
    pfx_t  pfx;
    logic  err_ws;
    logic  err_v6;
  } tok_t;

  typedef struct packed {
    logic       valid_res;
    logic [1:0] family;
    logic       has_prefix;
    logic [7:0] prefix_len;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
  endfunction

  // decimal accumulate, value stays below 1000 while length is under three
  function automatic logic [9:0] dec_acc(input logic [9:0] v, input logic [7:0] c);
    return 10'((v << 3) + (v << 1) + {6'd0, c[3:0]});
  endfunction

  function automatic logic octet_ok(input quad_t q);
    return (q.olen != 2'd0) && (q.oval <= OCTET_MAX) &&
           !((q.olen == OCTET_MAX_LEN) && q.first_zero);
  endfunction

  function automatic logic quad_done(input quad_t q);
    return !q.bad && (q.dots == V4_DOTS) && octet_ok(q);
  endfunction

  function automatic tok_t tok_clear();
    tok_t t;
    t = '0;
    t.trim = TRIM_LEAD;
    t.v6.part_hex = 1'b1;
    return t;
  endfunction

endpackage

// File: hw/rtl/civ_if.sv
`timescale 1ns / 1ps
interface civ_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface civ_res_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [1:0] family;
  logic       has_prefix;
  logic [7:0] prefix_len;

  modport source (output valid, valid_res, family, has_prefix, prefix_len, input ready);
  modport sink   (input valid, valid_res, family, has_prefix, prefix_len, output ready);
endinterface

interface civ_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/civ_quad.sv
`timescale 1ns / 1ps
module civ_quad (
  input  civ_pkg::quad_t q,
  input  logic [7:0]     ch,
  output civ_pkg::quad_t q_next
);

  always_comb begin
    q_next = q;
    if (civ_pkg::is_digit(ch)) begin
      if (q.olen == civ_pkg::OCTET_MAX_LEN) begin
        q_next.bad = 1'b1;
      end else begin
        if (q.olen == 2'd0) begin
          q_next.first_zero = (ch == civ_pkg::CH_ZERO);
        end
        q_next.oval = civ_pkg::dec_acc(q.oval, ch);
        q_next.olen = q.olen + 2'd1;
      end
    end else if (ch == civ_pkg::CH_DOT) begin
      if (!civ_pkg::octet_ok(q) || q.dots == civ_pkg::V4_DOTS) begin
        q_next.bad = 1'b1;
      end else begin
        q_next.dots = q.dots + 2'd1;
      end
      q_next.olen = 2'd0;
      q_next.oval = 10'd0;
      q_next.first_zero = 1'b0;
    end else begin
      q_next.bad = 1'b1;
    end
  end

endmodule

// File: hw/rtl/civ_tracker.sv
`timescale 1ns / 1ps
module civ_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [7:0]    ch,
  input  logic          last,
  input  logic [1:0]    mode,
  output civ_pkg::res_t res
);

  civ_pkg::tok_t  tok;
  civ_pkg::tok_t  tok_next;
  civ_pkg::quad_t v4_fed;
  civ_pkg::quad_t tail_fed;

  civ_quad u_v4 (
    .q      (tok.v4),
    .ch     (ch),
    .q_next (v4_fed)
  );

  civ_quad u_tail (
    .q      (tok.tail),
    .ch     (ch),
    .q_next (tail_fed)
  );

  // per character state update
  always_comb begin
    tok_next = tok;
    if (civ_pkg::is_space(ch)) begin
      if (tok.trim == civ_pkg::TRIM_IN) begin
        tok_next.trim = civ_pkg::TRIM_TAIL;
      end
    end else begin
      if (tok.trim == civ_pkg::TRIM_TAIL) begin
        tok_next.err_ws = 1'b1;
      end
      tok_next.trim = civ_pkg::TRIM_IN;
      if (!tok.pfx.slash_seen) begin
        if (ch == civ_pkg::CH_SLASH) begin
          tok_next.pfx.slash_seen = 1'b1;
        end else begin
          tok_next.v4 = v4_fed;
          if (ch == civ_pkg::CH_COLON) begin
            if (tok.v6.part_dot) begin
              tok_next.err_v6 = 1'b1;
            end else if (tok.v6.part_len == 3'd0) begin
              tok_next.v6.empty_part = 1'b1;
            end else if (tok.v6.part_len <= civ_pkg::HEX_MAX_LEN && tok.v6.part_hex) begin
              if (tok.v6.groups != civ_pkg::GROUPS_SAT) begin
                tok_next.v6.groups = tok.v6.groups + 4'd1;
              end
            end else begin
              tok_next.err_v6 = 1'b1;
            end
            if (tok.v6.run != civ_pkg::RUN_SAT) begin
              tok_next.v6.run = tok.v6.run + 2'd1;
            end
            if (tok_next.v6.run == civ_pkg::RUN_SAT) begin
              tok_next.err_v6 = 1'b1;
            end
            if (tok_next.v6.run == 2'd2) begin
              if (tok.v6.dcolon != civ_pkg::DCOLON_SAT) begin
                tok_next.v6.dcolon = tok.v6.dcolon + 2'd1;
              end
              if (tok_next.v6.dcolon == civ_pkg::DCOLON_SAT) begin
                tok_next.err_v6 = 1'b1;
              end
            end
            tok_next.v6.colon_seen = 1'b1;
            tok_next.v6.part_len = 3'd0;
            tok_next.v6.part_hex = 1'b1;
            tok_next.v6.part_dot = 1'b0;
            tok_next.tail = '0;
          end else begin
            tok_next.v6.run = 2'd0;
            if (ch == civ_pkg::CH_DOT) begin
              tok_next.v6.part_dot = 1'b1;
              tok_next.v6.part_hex = 1'b0;
            end else if (!civ_pkg::is_hex(ch)) begin
              tok_next.err_v6 = 1'b1;
            end
            if (tok.v6.part_len != civ_pkg::PART_LEN_SAT) begin
              tok_next.v6.part_len = tok.v6.part_len + 3'd1;
            end
            tok_next.tail = tail_fed;
          end
        end
      end else if (civ_pkg::is_digit(ch)) begin
        if (tok.pfx.plen < civ_pkg::PFX_MAX_LEN) begin
          tok_next.pfx.pval = civ_pkg::dec_acc(tok.pfx.pval, ch);
        end
        if (tok.pfx.plen != civ_pkg::PFX_LEN_SAT) begin
          tok_next.pfx.plen = tok.pfx.plen + 3'd1;
        end
      end else begin
        tok_next.pfx.bad = 1'b1;
      end
    end
  end

  // end of token verdict
  logic       v6_fail;
  logic       v6_empty;
  logic [4:0] v6_groups;
  logic       v6_ok;
  logic       pfx_shape_ok;
  logic       pfx_ok4;
  logic       pfx_ok6;
  logic       ok4;
  logic       ok6;
  logic [1:0] fam;
  logic       hp;

  always_comb begin
    v6_fail = tok_next.err_v6 || !tok_next.v6.colon_seen;
    v6_empty = tok_next.v6.empty_part;
    v6_groups = {1'b0, tok_next.v6.groups};
    if (tok_next.v6.part_dot) begin
      if (!civ_pkg::quad_done(tok_next.tail)) begin
        v6_fail = 1'b1;
      end
      v6_groups = v6_groups + 5'd2;
    end else if (tok_next.v6.part_len == 3'd0) begin
      v6_empty = 1'b1;
    end else if (tok_next.v6.part_len <= civ_pkg::HEX_MAX_LEN && tok_next.v6.part_hex) begin
      v6_groups = v6_groups + 5'd1;
    end else begin
      v6_fail = 1'b1;
    end
    if (tok_next.v6.dcolon != 2'd0) begin
      v6_ok = !v6_fail && (v6_groups < civ_pkg::V6_GROUPS);
    end else begin
      v6_ok = !v6_fail && (v6_groups == civ_pkg::V6_GROUPS) && !v6_empty;
    end

    pfx_shape_ok = !tok_next.pfx.bad && (tok_next.pfx.plen != 3'd0) &&
                   (tok_next.pfx.plen <= civ_pkg::PFX_MAX_LEN);
    pfx_ok4 = !tok_next.pfx.slash_seen ||
              (pfx_shape_ok && tok_next.pfx.pval <= civ_pkg::V4_MAX_BITS);
    pfx_ok6 = !tok_next.pfx.slash_seen ||
              (pfx_shape_ok && tok_next.pfx.pval <= civ_pkg::V6_MAX_BITS);

    ok4 = !tok_next.err_ws && (mode != civ_pkg::MODE_V6) &&
          civ_pkg::quad_done(tok_next.v4) && pfx_ok4;
    ok6 = !tok_next.err_ws && (mode != civ_pkg::MODE_V4) && v6_ok && pfx_ok6;

    if (ok4) begin
      fam = civ_pkg::FAM_V4;
    end else if (ok6) begin
      fam = civ_pkg::FAM_V6;
    end else begin
      fam = civ_pkg::FAM_NONE;
    end
    hp = (fam != civ_pkg::FAM_NONE) && tok_next.pfx.slash_seen;

    res.valid_res  = (fam != civ_pkg::FAM_NONE);
    res.family     = fam;
    res.has_prefix = hp;
    res.prefix_len = hp ? tok_next.pfx.pval[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= civ_pkg::tok_clear();
    end else if (en) begin
      tok <= last ? civ_pkg::tok_clear() : tok_next;
    end
  end

endmodule

// File: hw/rtl/ip_literal_cidr_validator.sv
`timescale 1ns / 1ps
// one character per cycle; a character is registered at acceptance and
// folded into the token state once it is processed
// the result is registered at the same edge that folds in the final character
// throughput: one character per cycle, set by the single state update stage;
// a final character waits only while an earlier result is still untaken
// reset (synchronous, rst high) empties both stages, clears the token, mode = either
module ip_literal_cidr_validator (
  input  logic         clk,
  input  logic         rst,
  civ_item_if.sink     item,
  civ_cfg_if.sink      cfg,
  civ_res_if.source    res
);

  logic          in_v;
  logic [7:0]    in_ch;
  logic          in_last;
  logic          out_v;
  civ_pkg::res_t out_r;
  logic [1:0]    mode;
  logic          process;
  civ_pkg::res_t res_next;

  assign process    = in_v && (!in_last || !out_v || res.ready);
  assign item.ready = !in_v || process;
  assign cfg.ready  = 1'b1;

  civ_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .en   (process),
    .ch   (in_ch),
    .last (in_last),
    .mode (mode),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      out_v <= 1'b0;
      mode  <= civ_pkg::MODE_RESET;
    end else begin
      if (item.ready) begin
        in_v <= item.valid;
      end
      if (process && in_last) begin
        out_v <= 1'b1;
      end else if (res.ready) begin
        out_v <= 1'b0;
      end
      if (cfg.valid) begin
        mode <= cfg.data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_ch   <= item.ch;
      in_last <= item.last;
    end
    if (process && in_last) begin
      out_r <= res_next;
    end
  end

  assign res.valid      = out_v;
  assign res.valid_res  = out_r.valid_res;
  assign res.family     = out_r.family;
  assign res.has_prefix = out_r.has_prefix;
  assign res.prefix_len = out_r.prefix_len;

endmodule

// File: hw/rtl/civ_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module civ_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       valid_res,
  input logic [1:0] family,
  input logic       has_prefix,
  input logic [7:0] prefix_len
);

  logic [11:0] res_bits;
  logic        res_stall;
  logic        fam_legal;
  logic        verdict_ok;
  logic        res_empty;
  logic        pfx_legal;

  assign res_bits   = {valid_res, family, has_prefix, prefix_len};
  assign res_stall  = res_valid && !res_ready;
  assign fam_legal  = (family == civ_pkg::FAM_NONE) || (family == civ_pkg::FAM_V4) ||
                      (family == civ_pkg::FAM_V6);
  assign verdict_ok = fam_legal && (valid_res == (family != civ_pkg::FAM_NONE));
  assign res_empty  = !has_prefix && (prefix_len == 8'd0);
  assign pfx_legal  = ((family == civ_pkg::FAM_V4) &&
                       ({2'd0, prefix_len} <= civ_pkg::V4_MAX_BITS)) ||
                      ((family == civ_pkg::FAM_V6) &&
                       ({2'd0, prefix_len} <= civ_pkg::V6_MAX_BITS));

  `CIV_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !res_valid, "result valid right after reset")

  `CIV_ASSERT(a_hold_stalled, res_stall |=> res_valid && $stable(res_bits), "stalled result changed")

  `CIV_ASSERT(a_verdict_family, res_valid |-> verdict_ok, "verdict and family disagree")

  `CIV_ASSERT(a_reject_zero, res_valid && !valid_res |-> res_empty, "rejected item carries a prefix")

  `CIV_ASSERT(a_prefix_range, res_valid && has_prefix |-> pfx_legal, "prefix out of range")

endmodule

bind ip_literal_cidr_validator civ_checker u_civ_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .valid_res  (res.valid_res),
  .family     (res.family),
  .has_prefix (res.has_prefix),
  .prefix_len (res.prefix_len)
);
